### sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Clocked assertion that is also checked across reset.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

### sv/dqnh_pkg.sv
// Types and constants of the DNS query name hasher.
// No dependencies; used by every module of the block except dqnh_fifo.
`default_nettype none

package dqnh_pkg;

    typedef enum logic [2:0] {
        ST_HASHED     = 3'd0,
        ST_NOT_IPV4   = 3'd1,
        ST_NOT_UDP    = 3'd2,
        ST_OTHER_PORT = 3'd3,
        ST_TRUNCATED  = 3'd4
    } t_status;

    // One entry of the front-to-back queue: an optional word mix and an
    // optional frame end, both caused by the same byte.
    typedef struct packed {
        logic        mix;
        logic        first;
        logic [31:0] word;
        logic        last;
        t_status     status;
        logic [7:0]  name_len;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [31:0] hash;
        logic [7:0]  name_len;
    } t_result;

    // Block mix constants
    localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2 = 32'h1b873593;
    localparam logic [31:0] MIX_C3 = 32'he6546b64;

    // Frame offsets
    localparam int unsigned OFS_ETYPE_HI = 12;
    localparam int unsigned OFS_ETYPE_LO = 13;
    localparam int unsigned OFS_PROTO    = 23;
    localparam int unsigned OFS_PORT_HI  = 36;
    localparam int unsigned OFS_PORT_LO  = 37;
    localparam int unsigned OFS_NAME     = 54;
    localparam int unsigned END_ETH      = 14;
    localparam int unsigned END_IP       = 34;
    localparam int unsigned END_UDP      = 42;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // Configuration registers
    localparam logic [0:0]  CFG_DNS_PORT    = 1'b0;
    localparam logic [0:0]  CFG_HASH_SEED   = 1'b1;
    localparam logic [15:0] DNS_PORT_RESET  = 16'd53;
    localparam logic [31:0] HASH_SEED_RESET = 32'd0;

    localparam int CMD_FIFO_DEPTH = 4;
    localparam int RES_FIFO_DEPTH = 2;

endpackage

`default_nettype wire

### sv/dqnh_fifo.sv
// Small first-word-fall-through queue with registered read data.
// Generic over the entry type; no package dependency.
`default_nettype none

module dqnh_fifo #(
    parameter int  DEPTH = 4,
    parameter type T     = logic [7:0]
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire T     i_data,
    input  wire logic i_pop,
    output T          o_data,
    output logic      o_full,
    output logic      o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    T               r_q;
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr;
    logic [AW-1:0]  n_rd;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_q;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd    = do_pop ? ((r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1)) : r_rd;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        // Pass the write straight through when it lands on the next head.
        if (do_push && (r_wr == n_rd)) begin
            r_q <= i_data;
        end else begin
            r_q <= r_mem[n_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            r_rd <= n_rd;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/dqnh_front.sv
// Front end: parses frame bytes, packs name words, classifies the frame.
// Depends on dqnh_pkg; feeds the command queue.
`default_nettype none

module dqnh_front #(
    parameter int MAX_NAME_BYTES  = 253,
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    input  wire logic [15:0]   i_dns_port,
    input  wire logic          i_cmd_full,
    output logic               o_cmd_push,
    output dqnh_pkg::t_cmd     o_cmd
);

    localparam int OW = $clog2(MAX_FRAME_BYTES + 1);

    typedef enum logic [1:0] {
        PH_BEFORE,
        PH_IN,
        PH_DONE
    } t_phase;

    logic [OW-1:0]     r_offset, n_offset;
    logic [15:0]       r_etype, n_etype;
    logic [7:0]        r_proto, n_proto;
    logic [15:0]       r_port, n_port;
    logic [31:0]       r_word, n_word;
    logic [7:0]        r_count, n_count;
    t_phase            r_phase, n_phase;
    logic [31:0]       word_or;
    logic              mix;
    logic              first;
    logic              accept;
    dqnh_pkg::t_status status;

    assign accept = i_valid && !i_cmd_full;

    always_comb begin
        n_offset = r_offset;
        n_etype  = r_etype;
        n_proto  = r_proto;
        n_port   = r_port;
        n_word   = r_word;
        n_count  = r_count;
        n_phase  = r_phase;
        word_or  = r_word;
        mix      = 1'b0;
        first    = (r_count[7:2] == 6'd0);

        if (r_offset < OW'(MAX_FRAME_BYTES)) begin
            n_offset = r_offset + OW'(1);
            if (r_offset == OW'(dqnh_pkg::OFS_ETYPE_HI)) begin
                n_etype = {i_byte, 8'h00};
            end else if (r_offset == OW'(dqnh_pkg::OFS_ETYPE_LO)) begin
                n_etype = {r_etype[15:8], i_byte};
            end else if (r_offset == OW'(dqnh_pkg::OFS_PROTO)) begin
                n_proto = i_byte;
            end else if (r_offset == OW'(dqnh_pkg::OFS_PORT_HI)) begin
                n_port = {i_byte, 8'h00};
            end else if (r_offset == OW'(dqnh_pkg::OFS_PORT_LO)) begin
                n_port = {r_port[15:8], i_byte};
            end else if (r_offset >= OW'(dqnh_pkg::OFS_NAME)) begin
                if (r_phase == PH_BEFORE) begin
                    n_phase = PH_IN;
                    n_word  = '0;
                    n_count = '0;
                end
                if (n_phase == PH_IN) begin
                    if (i_byte == 8'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        word_or = n_word | (32'(i_byte) << {n_count[1:0], 3'b000});
                        if (n_count[1:0] == 2'd3) begin
                            mix    = 1'b1;
                            n_word = '0;
                        end else begin
                            n_word = word_or;
                        end
                        n_count = n_count + 8'd1;
                        if (n_count >= 8'(MAX_NAME_BYTES)) begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
        end

        // Checks in header order, on the state after this byte
        if (n_offset < OW'(dqnh_pkg::END_ETH)) begin
            status = dqnh_pkg::ST_TRUNCATED;
        end else if (n_etype != dqnh_pkg::ETYPE_IPV4) begin
            status = dqnh_pkg::ST_NOT_IPV4;
        end else if (n_offset < OW'(dqnh_pkg::END_IP)) begin
            status = dqnh_pkg::ST_TRUNCATED;
        end else if (n_proto != dqnh_pkg::PROTO_UDP) begin
            status = dqnh_pkg::ST_NOT_UDP;
        end else if (n_offset < OW'(dqnh_pkg::END_UDP)) begin
            status = dqnh_pkg::ST_TRUNCATED;
        end else if (n_port != i_dns_port) begin
            status = dqnh_pkg::ST_OTHER_PORT;
        end else if (n_phase != PH_DONE) begin
            status = dqnh_pkg::ST_TRUNCATED;
        end else begin
            status = dqnh_pkg::ST_HASHED;
        end
    end

    always_comb begin
        o_cmd_push     = accept && (mix || i_last);
        o_cmd.mix      = mix;
        o_cmd.first    = first;
        o_cmd.word     = word_or;
        o_cmd.last     = i_last;
        o_cmd.status   = status;
        o_cmd.name_len = (status == dqnh_pkg::ST_HASHED) ? n_count : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_offset <= '0;
            r_etype  <= '0;
            r_proto  <= '0;
            r_port   <= '0;
            r_word   <= '0;
            r_count  <= '0;
            r_phase  <= PH_BEFORE;
        end else if (accept) begin
            r_offset <= n_offset;
            r_etype  <= n_etype;
            r_proto  <= n_proto;
            r_port   <= n_port;
            r_word   <= n_word;
            r_count  <= n_count;
            r_phase  <= n_phase;
        end
    end

endmodule

`default_nettype wire

### sv/dqnh_back.sv
// Back end: runs the block mix over queued name words and forms results.
// Depends on dqnh_pkg; drains the command queue, fills the result queue.
`default_nettype none

module dqnh_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    input  wire dqnh_pkg::t_cmd  i_cmd,
    input  wire logic [31:0]     i_seed,
    input  wire logic            i_res_full,
    output logic                 o_cmd_pop,
    output logic                 o_res_push,
    output dqnh_pkg::t_result    o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL2,
        S_MIX,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [31:0] r_k;
    logic [31:0] r_h;
    logic        r_mixed;
    logic [31:0] h_base;
    logic [31:0] h_xor;
    logic [31:0] h_rot;
    logic [31:0] h_next;
    logic [31:0] k_rot;

    assign k_rot  = {r_k[16:0], r_k[31:17]};
    assign h_base = i_cmd.first ? i_seed : r_h;
    assign h_xor  = h_base ^ r_k;
    assign h_rot  = {h_xor[18:0], h_xor[31:19]};
    // times five is the word plus itself shifted by two
    assign h_next = h_rot + {h_rot[29:0], 2'b00} + dqnh_pkg::MIX_C3;

    assign o_cmd_pop  = ((r_state == S_MIX) && !i_cmd.last)
                     || ((r_state == S_DONE) && !i_res_full);
    assign o_res_push = (r_state == S_DONE) && !i_res_full;

    always_comb begin
        o_res.status   = i_cmd.status;
        o_res.name_len = i_cmd.name_len;
        if (i_cmd.status != dqnh_pkg::ST_HASHED) begin
            o_res.hash = '0;
        end else if (r_mixed) begin
            o_res.hash = r_h;
        end else begin
            o_res.hash = i_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mixed <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.mix) begin
                            r_k     <= i_cmd.word * dqnh_pkg::MIX_C1;
                            r_state <= S_MUL2;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL2: begin
                    r_k     <= k_rot * dqnh_pkg::MIX_C2;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_h     <= h_next;
                    r_mixed <= 1'b1;
                    r_state <= i_cmd.last ? S_DONE : S_IDLE;
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_mixed <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/dns_query_name_hasher.sv
// DNS query name hasher top level: config registers, front, queues, back.
// Depends on dqnh_pkg, dqnh_fifo, dqnh_front and dqnh_back.
//
// Feed an Ethernet frame one byte per transfer, destination MAC first, with
// i_frame_last on the final byte. The block checks for IPv4, assuming a 20-byte
// header, UDP, and a destination port equal to register 0 (dns_port, reset
// 53), then runs the MurmurHash3 x86_32 block mix over every whole four-byte
// little-endian word of the query name at frame offset 54, starting from
// register 1 (hash_seed, reset 0). The name ends at a zero byte or after
// MAX_NAME_BYTES bytes; there is no tail and no finalization. Each frame
// yields exactly one result transfer carrying status (0 hashed, 1 not IPv4,
// 2 not UDP, 3 other port, 4 truncated), the hash and the name length; the
// last two read zero unless status is 0. Bytes past MAX_FRAME_BYTES are
// ignored but i_frame_last still closes the frame. Rate: the front takes one
// byte per cycle while full is low; the back end's multiply/rotate sequencer
// takes each completed name word through S_IDLE, S_MUL2 and S_MIX, each frame
// end through S_DONE, and an end-only entry through S_IDLE and S_DONE, so long
// frames stream at one byte per cycle and only runs of frames shorter than
// about two bytes fill the 4-entry command queue and raise full; a consumer
// that leaves results waiting raises it too once both queues fill. A result
// passes through the command queue, the back end and the result queue.
// Write configuration only while no frame is in flight or waiting.
`default_nettype none

module dns_query_name_hasher #(
    parameter int MAX_NAME_BYTES  = 253,
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input, queue style
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_frame_last,
    // result output, queue style
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_status,
    output logic [31:0]      o_name_hash,
    output logic [7:0]       o_name_length,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [15:0]          r_dns_port;
    logic [31:0]          r_hash_seed;

    logic                 cmd_push;
    logic                 cmd_pop;
    logic                 cmd_full;
    logic                 cmd_empty;
    dqnh_pkg::t_cmd       cmd_in;
    dqnh_pkg::t_cmd       cmd_head;

    logic                 res_push;
    logic                 res_full;
    dqnh_pkg::t_result    res_in;
    dqnh_pkg::t_result    res_head;

    // Configuration registers: written at once, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dns_port  <= dqnh_pkg::DNS_PORT_RESET;
            r_hash_seed <= dqnh_pkg::HASH_SEED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dqnh_pkg::CFG_DNS_PORT:  r_dns_port  <= i_cfg_data[15:0];
                dqnh_pkg::CFG_HASH_SEED: r_hash_seed <= i_cfg_data;
            endcase
        end
    end

    // Front: parse and classify; stall the byte stream only on a full queue
    dqnh_front #(
        .MAX_NAME_BYTES  (MAX_NAME_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push),
        .i_byte     (i_frame_byte),
        .i_last     (i_frame_last),
        .i_dns_port (r_dns_port),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    assign full = cmd_full;

    // Decouple front and back so a slow mix blocks the byte stream only once this queue fills
    dqnh_fifo #(
        .DEPTH (dqnh_pkg::CMD_FIFO_DEPTH),
        .T     (dqnh_pkg::t_cmd)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    // Back: block mix sequencer and result forming
    dqnh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_head),
        .i_seed      (r_hash_seed),
        .i_res_full  (res_full),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Hold finished results until the consumer takes them
    dqnh_fifo #(
        .DEPTH (dqnh_pkg::RES_FIFO_DEPTH),
        .T     (dqnh_pkg::t_result)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_status      = res_head.status;
    assign o_name_hash   = res_head.hash;
    assign o_name_length = res_head.name_len;

endmodule

`default_nettype wire

### sv/dqnh_checker.sv
// Port-level checker for the DNS query name hasher, bound to the top level.
// Depends on dqnh_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dqnh_checker #(
    parameter int MAX_NAME_BYTES = 253
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_name_hash,
    input wire logic [7:0]  o_name_length
);

    // no result survives reset
    `ASSERT_CLK(a_empty_after_reset, i_clk, !i_rst_n |=> empty)

    // a waiting result holds until transferred
    `ASSERT_CLKD(a_result_holds, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_name_hash) && $stable(o_name_length)))

    // failed frames carry no hash and no length
    `ASSERT_CLKD(a_fail_zeroed, i_clk, i_rst_n, (!empty && (o_status != 3'(dqnh_pkg::ST_HASHED))) |-> ((o_name_hash == 32'd0) && (o_name_length == 8'd0)))

    // status code and name length stay in range
    `ASSERT_CLKD(a_result_range, i_clk, i_rst_n, !empty |-> ((o_status <= 3'(dqnh_pkg::ST_TRUNCATED)) && (o_name_length <= 8'(MAX_NAME_BYTES))))

endmodule

bind dns_query_name_hasher dqnh_checker #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
) u_dqnh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_status      (o_status),
    .o_name_hash   (o_name_hash),
    .o_name_length (o_name_length)
);

`default_nettype wire

### tb/tb_dns_query_name_hasher.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DNS query name hasher: Ethernet frames go in
// byte by byte, and each frame-end result is checked against an in-bench model or a typed-in row.
// Depends on dqnh_pkg (status codes, offsets, register indexes) and the block.

module tb_dns_query_name_hasher;

    localparam int     NAME_LIMIT    = 253;
    localparam int     FRAME_LIMIT   = 2048;
    localparam int     SETTLE_CYCLES = 16;      // lets the back end settle and a stray result show up
    localparam int     PHASE_BYTES   = 80;
    localparam int     PHASE_FRAMES  = 1;
    localparam int     NUM_PHASES    = 4;
    localparam int     NUM_DIRECTED  = 22;
    localparam longint TIMEOUT_NS    = 20_000_000;

    // One frame to send. The name is name_len nonzero bytes followed by a zero
    // byte; a name_fill of zero means random nonzero name bytes.
    typedef struct packed {
        int                len;
        logic [15:0]       etype;
        logic [7:0]        proto;
        logic [15:0]       port;
        int                name_len;
        logic [7:0]        name_fill;
        logic              cfg_first;
        logic [15:0]       cfg_port;
        logic [31:0]       cfg_seed;
        logic              pinned;
        dqnh_pkg::t_result want;
    } t_frame_row;

    typedef enum logic [1:0] {
        NAME_BEFORE,
        NAME_INSIDE,
        NAME_DONE
    } t_name_state;

    localparam dqnh_pkg::t_result RES_NONE       = '{dqnh_pkg::ST_HASHED, 32'h0, 8'h0};
    localparam dqnh_pkg::t_result RES_TRUNC      = '{dqnh_pkg::ST_TRUNCATED, 32'h0, 8'h0};
    localparam dqnh_pkg::t_result RES_NOT_IPV4   = '{dqnh_pkg::ST_NOT_IPV4, 32'h0, 8'h0};
    localparam dqnh_pkg::t_result RES_NOT_UDP    = '{dqnh_pkg::ST_NOT_UDP, 32'h0, 8'h0};
    localparam dqnh_pkg::t_result RES_OTHER_PORT = '{dqnh_pkg::ST_OTHER_PORT, 32'h0, 8'h0};

    // Directed frames. Expected results are typed in only where they are
    // obvious; the remaining rows are checked against the model below.
    localparam t_frame_row DIRECTED [NUM_DIRECTED] = '{
        // len  etype     proto  port      nlen fill   cfg   cport      cseed   pin   want
        // header cut short at every stage
        '{1,    16'h0800, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        '{13,   16'h0800, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        '{14,   16'h0801, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1,
          RES_NOT_IPV4},
        '{14,   16'h0800, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        '{33,   16'h0800, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        '{34,   16'h0800, 8'd6,  16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1,
          RES_NOT_UDP},
        '{34,   16'h0800, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        '{41,   16'h0800, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        // port in the wrong byte order must not match
        '{42,   16'h0800, 8'd17, 16'h3500, 0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1,
          RES_OTHER_PORT},
        // good port but the name never finishes
        '{42,   16'h0800, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        '{54,   16'h0800, 8'd17, 16'd53,   5,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        // empty name and a name shorter than one word leave the seed untouched
        '{55,   16'h0800, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1,
          '{dqnh_pkg::ST_HASHED, 32'h0, 8'd0}},
        '{58,   16'h0800, 8'd17, 16'd53,   3,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1,
          '{dqnh_pkg::ST_HASHED, 32'h0, 8'd3}},
        // high bytes must mix as unsigned
        '{60,   16'h0800, 8'd17, 16'd53,   5,   8'hff, 1'b0, 16'h0000, 32'h0, 1'b0, RES_NONE},
        '{75,   16'h0800, 8'd17, 16'd53,   20,  8'h00, 1'b0, 16'h0000, 32'h0, 1'b0, RES_NONE},
        '{58,   16'h0800, 8'd17, 16'd53,   8,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1, RES_TRUNC},
        // name stopped by the length limit
        '{314,  16'h0800, 8'd17, 16'd53,   300, 8'h00, 1'b0, 16'h0000, 32'h0, 1'b0, RES_NONE},
        // all-ones ether type
        '{20,   16'hffff, 8'd17, 16'd53,   0,   8'h00, 1'b0, 16'h0000, 32'h0, 1'b1,
          RES_NOT_IPV4},
        // smallest port, largest seed
        '{55,   16'h0800, 8'd17, 16'h0000, 0,   8'h00, 1'b1, 16'h0000, 32'hffffffff, 1'b1,
          '{dqnh_pkg::ST_HASHED, 32'hffffffff, 8'd0}},
        '{80,   16'h0800, 8'd17, 16'h0000, 16,  8'h80, 1'b0, 16'h0000, 32'h0, 1'b0, RES_NONE},
        // largest port; low byte differs
        '{42,   16'h0800, 8'd17, 16'hff00, 0,   8'h00, 1'b1, 16'hffff, 32'h12345678, 1'b1,
          RES_OTHER_PORT},
        '{70,   16'h0800, 8'd17, 16'hffff, 10,  8'h00, 1'b0, 16'h0000, 32'h0, 1'b0, RES_NONE}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic [7:0]  i_frame_byte  = 8'h00;
    logic        i_frame_last  = 1'b0;
    logic        empty;
    logic        pop           = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_name_hash;
    logic [7:0]  o_name_length;
    logic        i_cfg_we      = 1'b0;
    logic [0:0]  i_cfg_index   = dqnh_pkg::CFG_DNS_PORT;
    logic [31:0] i_cfg_data    = 32'h0;

    // Model copy of the configuration registers
    logic [15:0] cur_dns_port  = dqnh_pkg::DNS_PORT_RESET;
    logic [31:0] cur_hash_seed = dqnh_pkg::HASH_SEED_RESET;

    // Model copy of the per-frame parse state
    int          scan_pos        = 0;
    logic [15:0] scan_etype      = 16'h0;
    logic [7:0]  scan_proto      = 8'h0;
    logic [15:0] scan_port       = 16'h0;
    logic [31:0] scan_word       = 32'h0;
    logic [31:0] scan_hash       = dqnh_pkg::HASH_SEED_RESET;
    logic [7:0]  scan_name_cnt   = 8'h0;
    t_name_state scan_name_state = NAME_BEFORE;

    dqnh_pkg::t_result due_results[$];
    int          fail_count = 0;
    bit          send_calm  = 1'b0;
    bit          recv_calm  = 1'b0;
    int          pop_wait   = 0;

    dns_query_name_hasher #(
        .MAX_NAME_BYTES (NAME_LIMIT),
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_frame_byte (i_frame_byte),
        .i_frame_last (i_frame_last),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_name_hash  (o_name_hash),
        .o_name_length(o_name_length),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle cycles before the next transfer on either side; calm stretches
    // run back to back.
    function automatic int draw_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Advance the model by one accepted frame byte. On the last byte, return
    // the frame's result and drop all per-frame state.
    task automatic hash_frame_byte(input logic [7:0] b, input logic last,
                                   output bit got, output dqnh_pkg::t_result res);
        logic [31:0]       k;
        logic [31:0]       h;
        dqnh_pkg::t_status verdict;
        got = 1'b0;
        res = RES_NONE;
        // Bytes beyond the size limit are dropped; the position saturates.
        if (scan_pos < FRAME_LIMIT) begin
            if (scan_pos == dqnh_pkg::OFS_ETYPE_HI) scan_etype = {b, 8'h00};
            else if (scan_pos == dqnh_pkg::OFS_ETYPE_LO) scan_etype = scan_etype | {8'h00, b};
            else if (scan_pos == dqnh_pkg::OFS_PROTO) scan_proto = b;
            else if (scan_pos == dqnh_pkg::OFS_PORT_HI) scan_port = {b, 8'h00};
            else if (scan_pos == dqnh_pkg::OFS_PORT_LO) scan_port = scan_port | {8'h00, b};
            else if (scan_pos >= dqnh_pkg::OFS_NAME) begin
                // The seed is picked up by the first name byte.
                if (scan_name_state == NAME_BEFORE) begin
                    scan_name_state = NAME_INSIDE;
                    scan_hash       = cur_hash_seed;
                    scan_word       = 32'h0;
                    scan_name_cnt   = 8'h0;
                end
                if (scan_name_state == NAME_INSIDE) begin
                    if (b == 8'h00) begin
                        scan_name_state = NAME_DONE;
                    end else begin
                        // Pack little-endian; mix each whole word.
                        scan_word = scan_word | ({24'h0, b} << (8 * scan_name_cnt[1:0]));
                        if (scan_name_cnt[1:0] == 2'd3) begin
                            k = scan_word * dqnh_pkg::MIX_C1;
                            k = {k[16:0], k[31:17]};
                            k = k * dqnh_pkg::MIX_C2;
                            h = scan_hash ^ k;
                            h = {h[18:0], h[31:19]};
                            scan_hash = h * 32'd5 + dqnh_pkg::MIX_C3;
                            scan_word = 32'h0;
                        end
                        scan_name_cnt = scan_name_cnt + 8'd1;
                        if (int'(scan_name_cnt) >= NAME_LIMIT) scan_name_state = NAME_DONE;
                    end
                end
            end
            scan_pos = scan_pos + 1;
        end
        if (last) begin
            // Checks run in header order; a field cut short means truncated.
            if (scan_pos < dqnh_pkg::END_ETH) verdict = dqnh_pkg::ST_TRUNCATED;
            else if (scan_etype != dqnh_pkg::ETYPE_IPV4) verdict = dqnh_pkg::ST_NOT_IPV4;
            else if (scan_pos < dqnh_pkg::END_IP) verdict = dqnh_pkg::ST_TRUNCATED;
            else if (scan_proto != dqnh_pkg::PROTO_UDP) verdict = dqnh_pkg::ST_NOT_UDP;
            else if (scan_pos < dqnh_pkg::END_UDP) verdict = dqnh_pkg::ST_TRUNCATED;
            else if (scan_port != cur_dns_port) verdict = dqnh_pkg::ST_OTHER_PORT;
            else if (scan_name_state != NAME_DONE) verdict = dqnh_pkg::ST_TRUNCATED;
            else verdict = dqnh_pkg::ST_HASHED;
            got        = 1'b1;
            res.status = verdict;
            if (verdict == dqnh_pkg::ST_HASHED) begin
                res.hash     = scan_hash;
                res.name_len = scan_name_cnt;
            end
            scan_pos        = 0;
            scan_etype      = 16'h0;
            scan_proto      = 8'h0;
            scan_port       = 16'h0;
            scan_word       = 32'h0;
            scan_hash       = cur_hash_seed;
            scan_name_cnt   = 8'h0;
            scan_name_state = NAME_BEFORE;
        end
    endtask

    // Write both registers while the block is idle: drain all results, let
    // the back end settle, then write one register per cycle.
    task automatic write_config(input logic [15:0] port, input logic [31:0] seed);
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= dqnh_pkg::CFG_DNS_PORT;
        i_cfg_data  <= {16'h0000, port};
        @(posedge i_clk);
        i_cfg_index <= dqnh_pkg::CFG_HASH_SEED;
        i_cfg_data  <= seed;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        cur_dns_port  = port;
        cur_hash_seed = seed;
    endtask

    // Send one frame. Each byte is held on the port until its transfer, then
    // fed to the model; the frame's result is queued on its last byte.
    task automatic push_frame(input t_frame_row row);
        logic [7:0]        b;
        logic              last;
        bit                got;
        dqnh_pkg::t_result seen;
        int                name_idx;
        int                gap;
        if (row.cfg_first) write_config(row.cfg_port, row.cfg_seed);
        send_calm = ($urandom_range(0, 3) == 0);
        for (int off = 0; off < row.len; off++) begin
            name_idx = off - int'(dqnh_pkg::OFS_NAME);
            if (off == dqnh_pkg::OFS_ETYPE_HI) b = row.etype[15:8];
            else if (off == dqnh_pkg::OFS_ETYPE_LO) b = row.etype[7:0];
            else if (off == dqnh_pkg::OFS_PROTO) b = row.proto;
            else if (off == dqnh_pkg::OFS_PORT_HI) b = row.port[15:8];
            else if (off == dqnh_pkg::OFS_PORT_LO) b = row.port[7:0];
            else if (name_idx >= 0 && name_idx < row.name_len)
                b = (row.name_fill != 8'h00) ? row.name_fill : 8'($urandom_range(1, 255));
            else if (name_idx >= 0 && name_idx == row.name_len) b = 8'h00;
            else b = 8'($urandom_range(0, 255));
            last = (off == row.len - 1);
            gap  = draw_gap(send_calm);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            push         <= 1'b1;
            i_frame_byte <= b;
            i_frame_last <= last;
            do @(posedge i_clk); while (!(push && !full));
            hash_frame_byte(b, last, got, seen);
            if (got) due_results.push_back(row.pinned ? row.want : seen);
        end
    endtask

    // Result side: stall pop for a random count after every transfer,
    // flipping into and out of calm stretches now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop && !empty) begin
            if ($urandom_range(0, 7) == 0) recv_calm = !recv_calm;
            pop_wait = draw_gap(recv_calm);
            pop <= (pop_wait == 0);
        end else if (!pop) begin
            if (pop_wait > 0) pop_wait = pop_wait - 1;
            if (pop_wait == 0) pop <= 1'b1;
        end
    end

    // Compare every result transfer, field by field, with the oldest
    // outstanding expectation.
    always @(posedge i_clk) begin : check_result
        dqnh_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d hash %h length %0d",
                         $time, o_status, o_name_hash, o_name_length);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_name_hash !== want.hash) begin
                    $display("%0t: name_hash mismatch, expected %h, got %h",
                             $time, want.hash, o_name_hash);
                    fail_count++;
                end
                if (o_name_length !== want.name_len) begin
                    $display("%0t: name_length mismatch, expected %0d, got %0d",
                             $time, want.name_len, o_name_length);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_frame_row  row;
        int          phase_bytes;
        int          phase_frames;
        int          kind;
        logic [15:0] port;
        logic [31:0] seed;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) push_frame(DIRECTED[r]);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    port = 16'($urandom);
                    seed = $urandom;
                end
                1: begin
                    port = 16'h0000;
                    seed = 32'hffffffff;
                end
                2: begin
                    port = 16'hffff;
                    seed = 32'h0;
                end
                default: begin
                    port = dqnh_pkg::DNS_PORT_RESET;
                    seed = $urandom;
                end
            endcase
            write_config(port, seed);
            phase_bytes  = 0;
            phase_frames = 0;
            while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
                // Start from a well-formed DNS request with a random name,
                // then break it for a minority of frames.
                row           = '0;
                row.etype     = dqnh_pkg::ETYPE_IPV4;
                row.proto     = dqnh_pkg::PROTO_UDP;
                row.port      = cur_dns_port;
                row.name_len  = ($urandom_range(0, 15) == 0) ? int'($urandom_range(200, 300))
                                                             : int'($urandom_range(0, 40));
                row.name_fill = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                            : 8'h00;
                row.len       = int'(dqnh_pkg::OFS_NAME) + row.name_len + 1
                              + int'($urandom_range(0, 6));
                kind          = int'($urandom_range(0, 15));
                case (kind)
                    10: begin
                        // short noise frame with random header fields
                        row.len = int'($urandom_range(1, 70));
                        if ($urandom_range(0, 1) == 0) row.etype = 16'($urandom);
                        if ($urandom_range(0, 1) == 0) row.proto = 8'($urandom);
                        if ($urandom_range(0, 1) == 0) row.port = 16'($urandom);
                    end
                    11: begin
                        do row.etype = 16'($urandom);
                        while (row.etype == dqnh_pkg::ETYPE_IPV4);
                    end
                    12: begin
                        do row.proto = 8'($urandom);
                        while (row.proto == dqnh_pkg::PROTO_UDP);
                    end
                    13: row.port = cur_dns_port ^ 16'($urandom_range(1, 65535));
                    15: row.len = int'($urandom_range(1, int'(dqnh_pkg::OFS_NAME)
                                                        + row.name_len));
                    default: ;
                endcase
                push_frame(row);
                phase_bytes += row.len;
                phase_frames++;
            end
        end

        // Drain, then give a stray result time to show up.
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

### dns_query_name_hasher.f
+incdir+sv
sv/dqnh_pkg.sv
sv/dqnh_fifo.sv
sv/dqnh_front.sv
sv/dqnh_back.sv
sv/dns_query_name_hasher.sv
sv/dqnh_checker.sv
tb/tb_dns_query_name_hasher.sv
